// ===== hdl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Shared opcodes, status codes, default widths and the pipeline control word.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DEF_DATA_WIDTH = 16;
  localparam int DEF_FRAC_BITS  = 8;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  // Control that travels with every word down the pipeline.
  typedef struct packed {
    logic valid;
    logic is_div;
    logic div0;
    logic sat;
  } ctl_t;

endpackage

// ===== hdl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipeline: input register, product stage, combine stage, the divider chain and
// the output register. Throughput: one word per cycle while the output is not
// stalled; the divider's one-bit-per-stage chain sets depth.
// A stalled output word freezes the whole pipeline, so nothing is lost or repeated.
// Reset: synchronous, active low; clears all valid bits, no clearing pass needed.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_opcode,
  input  logic signed [DATA_WIDTH-1:0]  in_a_re,
  input  logic signed [DATA_WIDTH-1:0]  in_a_im,
  input  logic signed [DATA_WIDTH-1:0]  in_b_re,
  input  logic signed [DATA_WIDTH-1:0]  in_b_im,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_res_re,
  output logic signed [DATA_WIDTH-1:0]  out_res_im,
  output logic [1:0]                    out_status
);

  localparam int DW = DATA_WIDTH;
  localparam int NW = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int QW = DATA_WIDTH + 2;
  // One divider stage per quotient bit, from weight DW+1 (overflow) down to 0.
  localparam int NS = DATA_WIDTH + 2;

  // The whole pipeline advances together whenever the output register can
  // take a new word: it is empty or its word is being taken this cycle.
  logic en;
  logic out_valid_r;
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Stage 1: input register.
  logic                 v1_r;
  opcode_t              op1_r;
  logic signed [DW-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= opcode_t'(in_opcode);
      ar1_r <= in_a_re;
      ai1_r <= in_a_im;
      br1_r <= in_b_re;
      bi1_r <= in_b_im;
    end
  end

  // Stage 2: the six operand products and the linear results.
  logic                   v2;
  opcode_t                op2;
  logic signed [2*DW-1:0] p_rr, p_ii, p_ir, p_ri, d_rr, d_ii;
  logic signed [DW:0]     lin_re, lin_im;

  cau_mult #(.DATA_WIDTH(DW)) u_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (v1_r),
    .op_i     (op1_r),
    .ar_i     (ar1_r),
    .ai_i     (ai1_r),
    .br_i     (br1_r),
    .bi_i     (bi1_r),
    .v_r      (v2),
    .op_r     (op2),
    .p_rr_r   (p_rr),
    .p_ii_r   (p_ii),
    .p_ir_r   (p_ir),
    .p_ri_r   (p_ri),
    .d_rr_r   (d_rr),
    .d_ii_r   (d_ii),
    .lin_re_r (lin_re),
    .lin_im_r (lin_im)
  );

  // Stage 3: sums of products; every opcode but divide is finished here.
  ctl_t                 c_s     [NS+1];
  logic signed [DW-1:0] rre_s   [NS+1];
  logic signed [DW-1:0] rim_s   [NS+1];
  logic [1:0]           neg_s   [NS+1];
  logic [2*DW-1:0]      den_s   [NS+1];
  logic [1:0][NW-1:0]   rem_s   [NS+1];
  logic [1:0][QW-1:0]   q_s     [NS+1];
  logic [1:0][2*DW-1:0] mag3;

  cau_combine #(.DATA_WIDTH(DW), .FRAC_BITS(FRAC_BITS)) u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .v_i      (v2),
    .op_i     (op2),
    .p_rr_i   (p_rr),
    .p_ii_i   (p_ii),
    .p_ir_i   (p_ir),
    .p_ri_i   (p_ri),
    .d_rr_i   (d_rr),
    .d_ii_i   (d_ii),
    .lin_re_i (lin_re),
    .lin_im_i (lin_im),
    .ctl_r    (c_s[0]),
    .res_re_r (rre_s[0]),
    .res_im_r (rim_s[0]),
    .neg_r    (neg_s[0]),
    .mag_r    (mag3),
    .den_r    (den_s[0])
  );

  // The dividend is the numerator magnitude scaled by the fraction bits.
  assign rem_s[0][0] = NW'(mag3[0]) << FRAC_BITS;
  assign rem_s[0][1] = NW'(mag3[1]) << FRAC_BITS;
  assign q_s[0]      = '0;

  // Divider chain: a restoring step per stage. A set top bit means the
  // quotient reached twice the output range, which always saturates.
  for (genvar k = 0; k < NS; k++) begin : g_div
    cau_div_stage #(
      .DATA_WIDTH (DW),
      .FRAC_BITS  (FRAC_BITS),
      .SHIFT      (NS - 1 - k)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .ctl_i    (c_s[k]),
      .res_re_i (rre_s[k]),
      .res_im_i (rim_s[k]),
      .neg_i    (neg_s[k]),
      .den_i    (den_s[k]),
      .rem_i    (rem_s[k]),
      .q_i      (q_s[k]),
      .ctl_r    (c_s[k+1]),
      .res_re_r (rre_s[k+1]),
      .res_im_r (rim_s[k+1]),
      .neg_r    (neg_s[k+1]),
      .den_r    (den_s[k+1]),
      .rem_r    (rem_s[k+1]),
      .q_r      (q_s[k+1])
    );
  end

  // Final select feeds the output register.
  logic signed [DW-1:0] fin_re, fin_im;
  status_t              fin_st;

  cau_pack #(.DATA_WIDTH(DW)) u_pack (
    .ctl_i    (c_s[NS]),
    .res_re_i (rre_s[NS]),
    .res_im_i (rim_s[NS]),
    .neg_i    (neg_s[NS]),
    .q_i      (q_s[NS]),
    .re_o     (fin_re),
    .im_o     (fin_im),
    .status_o (fin_st)
  );

  logic signed [DW-1:0] out_re_r, out_im_r;
  status_t              out_st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= c_s[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_re_r <= fin_re;
      out_im_r <= fin_im;
      out_st_r <= fin_st;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_res_re = out_re_r;
  assign out_res_im = out_im_r;
  assign out_status = out_st_r;

  localparam logic signed [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

`ifndef SYNTHESIS
  // A zero divisor always yields a zero result.
  a_div0_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DIV0 |-> out_res_re == '0 && out_res_im == '0)
    else $error("divide by zero word carries a nonzero result");

  // A saturated word has at least one part pinned to a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_SAT |->
      out_res_re == SMAX || out_res_re == SMIN ||
      out_res_im == SMAX || out_res_im == SMIN)
    else $error("saturated word has no part at a range limit");

  // Only the three defined status codes ever leave the unit.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code on output");
`endif

endmodule

// ===== hdl/cau_mult.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit, product stage
// Registers the six operand products and the add, subtract and negate sums.
// ----------------------------------------------------------------------------
module cau_mult import cau_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          v_i,
  input  opcode_t                       op_i,
  input  logic signed [DATA_WIDTH-1:0]  ar_i,
  input  logic signed [DATA_WIDTH-1:0]  ai_i,
  input  logic signed [DATA_WIDTH-1:0]  br_i,
  input  logic signed [DATA_WIDTH-1:0]  bi_i,
  output logic                          v_r,
  output opcode_t                       op_r,
  output logic signed [2*DATA_WIDTH-1:0] p_rr_r,
  output logic signed [2*DATA_WIDTH-1:0] p_ii_r,
  output logic signed [2*DATA_WIDTH-1:0] p_ir_r,
  output logic signed [2*DATA_WIDTH-1:0] p_ri_r,
  output logic signed [2*DATA_WIDTH-1:0] d_rr_r,
  output logic signed [2*DATA_WIDTH-1:0] d_ii_r,
  output logic signed [DATA_WIDTH:0]    lin_re_r,
  output logic signed [DATA_WIDTH:0]    lin_im_r
);

  localparam int DW = DATA_WIDTH;

  logic signed [DW:0] lin_re_nxt;
  logic signed [DW:0] lin_im_nxt;

  always_comb begin
    lin_re_nxt = '0;
    lin_im_nxt = '0;
    unique case (op_i)
      OP_ADD: begin
        lin_re_nxt = (DW+1)'(ar_i) + (DW+1)'(br_i);
        lin_im_nxt = (DW+1)'(ai_i) + (DW+1)'(bi_i);
      end
      OP_SUB: begin
        lin_re_nxt = (DW+1)'(ar_i) - (DW+1)'(br_i);
        lin_im_nxt = (DW+1)'(ai_i) - (DW+1)'(bi_i);
      end
      OP_NEG: begin
        lin_re_nxt = -(DW+1)'(ar_i);
        lin_im_nxt = -(DW+1)'(ai_i);
      end
      default: begin
        lin_re_nxt = '0;
        lin_im_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r     <= op_i;
      p_rr_r   <= (2*DW)'(ar_i) * (2*DW)'(br_i);
      p_ii_r   <= (2*DW)'(ai_i) * (2*DW)'(bi_i);
      p_ir_r   <= (2*DW)'(ai_i) * (2*DW)'(br_i);
      p_ri_r   <= (2*DW)'(ar_i) * (2*DW)'(bi_i);
      d_rr_r   <= (2*DW)'(br_i) * (2*DW)'(br_i);
      d_ii_r   <= (2*DW)'(bi_i) * (2*DW)'(bi_i);
      lin_re_r <= lin_re_nxt;
      lin_im_r <= lin_im_nxt;
    end
  end

endmodule

// ===== hdl/cau_combine.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit, combine stage
// Forms product sums, finishes add, subtract, negate and multiply, and prepares
// sign, magnitude and divisor for the divider.
// ----------------------------------------------------------------------------
module cau_combine import cau_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           v_i,
  input  opcode_t                        op_i,
  input  logic signed [2*DATA_WIDTH-1:0] p_rr_i,
  input  logic signed [2*DATA_WIDTH-1:0] p_ii_i,
  input  logic signed [2*DATA_WIDTH-1:0] p_ir_i,
  input  logic signed [2*DATA_WIDTH-1:0] p_ri_i,
  input  logic signed [2*DATA_WIDTH-1:0] d_rr_i,
  input  logic signed [2*DATA_WIDTH-1:0] d_ii_i,
  input  logic signed [DATA_WIDTH:0]     lin_re_i,
  input  logic signed [DATA_WIDTH:0]     lin_im_i,
  output ctl_t                           ctl_r,
  output logic signed [DATA_WIDTH-1:0]   res_re_r,
  output logic signed [DATA_WIDTH-1:0]   res_im_r,
  output logic [1:0]                     neg_r,
  output logic [1:0][2*DATA_WIDTH-1:0]   mag_r,
  output logic [2*DATA_WIDTH-1:0]        den_r
);

  localparam int DW = DATA_WIDTH;
  localparam int W1 = 2 * DATA_WIDTH + 1;

  function automatic logic [W1-1:0] abs_w(input logic signed [W1-1:0] s);
    return s[W1-1] ? W1'(-s) : W1'(s);
  endfunction

  // Returns {saturated, value} for a sign and magnitude.
  function automatic logic [DW:0] sat_pack(input logic neg, input logic [W1-1:0] mag);
    logic [W1-1:0] lim;
    logic [W1-1:0] m;
    lim = neg ? (W1'(1) << (DW-1)) : ((W1'(1) << (DW-1)) - W1'(1));
    m   = (mag > lim) ? lim : mag;
    m   = neg ? (~m + W1'(1)) : m;
    return {mag > lim, m[DW-1:0]};
  endfunction

  logic signed [W1-1:0] m_re, m_im, n_re, n_im, l_re, l_im;
  logic [W1-1:0]        n_re_mag, n_im_mag;
  logic [DW:0]          pk_re, pk_im;
  logic [2*DW-1:0]      den_nxt;
  ctl_t                 ctl_nxt;

  always_comb begin
    m_re     = W1'(p_rr_i) - W1'(p_ii_i);
    m_im     = W1'(p_ir_i) + W1'(p_ri_i);
    n_re     = W1'(p_rr_i) + W1'(p_ii_i);
    n_im     = W1'(p_ir_i) - W1'(p_ri_i);
    l_re     = W1'(lin_re_i);
    l_im     = W1'(lin_im_i);
    n_re_mag = abs_w(n_re);
    n_im_mag = abs_w(n_im);
    den_nxt  = $unsigned(d_rr_i) + $unsigned(d_ii_i);
    if (op_i == OP_MUL) begin
      pk_re = sat_pack(m_re[W1-1], abs_w(m_re) >> FRAC_BITS);
      pk_im = sat_pack(m_im[W1-1], abs_w(m_im) >> FRAC_BITS);
    end else begin
      pk_re = sat_pack(l_re[W1-1], abs_w(l_re));
      pk_im = sat_pack(l_im[W1-1], abs_w(l_im));
    end
    ctl_nxt.valid  = v_i;
    ctl_nxt.is_div = (op_i == OP_DIV);
    ctl_nxt.div0   = (op_i == OP_DIV) && (den_nxt == '0);
    ctl_nxt.sat    = pk_re[DW] | pk_im[DW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.is_div <= ctl_nxt.is_div;
      ctl_r.div0   <= ctl_nxt.div0;
      ctl_r.sat    <= ctl_nxt.sat;
      res_re_r     <= pk_re[DW-1:0];
      res_im_r     <= pk_im[DW-1:0];
      neg_r        <= {n_im[W1-1], n_re[W1-1]};
      mag_r[0]     <= n_re_mag[2*DW-1:0];
      mag_r[1]     <= n_im_mag[2*DW-1:0];
      den_r        <= den_nxt;
    end
  end

endmodule

// ===== hdl/cau_div_stage.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit, divider stage
// One restoring quotient bit at weight SHIFT for both parts of the quotient.
// ----------------------------------------------------------------------------
module cau_div_stage import cau_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH,
  parameter int FRAC_BITS  = DEF_FRAC_BITS,
  parameter int SHIFT      = 0
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     en,
  input  ctl_t                                     ctl_i,
  input  logic signed [DATA_WIDTH-1:0]             res_re_i,
  input  logic signed [DATA_WIDTH-1:0]             res_im_i,
  input  logic [1:0]                               neg_i,
  input  logic [2*DATA_WIDTH-1:0]                  den_i,
  input  logic [1:0][2*DATA_WIDTH+FRAC_BITS-1:0]   rem_i,
  input  logic [1:0][DATA_WIDTH+1:0]               q_i,
  output ctl_t                                     ctl_r,
  output logic signed [DATA_WIDTH-1:0]             res_re_r,
  output logic signed [DATA_WIDTH-1:0]             res_im_r,
  output logic [1:0]                               neg_r,
  output logic [2*DATA_WIDTH-1:0]                  den_r,
  output logic [1:0][2*DATA_WIDTH+FRAC_BITS-1:0]   rem_r,
  output logic [1:0][DATA_WIDTH+1:0]               q_r
);

  localparam int NW = 2 * DATA_WIDTH + FRAC_BITS;
  localparam int QW = DATA_WIDTH + 2;

  logic [1:0][NW-1:0] rem_nxt;
  logic [1:0][QW-1:0] q_nxt;
  logic [1:0]         take;

  // When the shifted remainder covers the divisor, the subtrahend fits too.
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      take[p]    = (rem_i[p] >> SHIFT) >= NW'(den_i);
      rem_nxt[p] = take[p] ? (rem_i[p] - (NW'(den_i) << SHIFT)) : rem_i[p];
      q_nxt[p]   = q_i[p] | (QW'(take[p]) << SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.is_div <= ctl_i.is_div;
      ctl_r.div0   <= ctl_i.div0;
      ctl_r.sat    <= ctl_i.sat;
      res_re_r     <= res_re_i;
      res_im_r     <= res_im_i;
      neg_r        <= neg_i;
      den_r        <= den_i;
      rem_r        <= rem_nxt;
      q_r          <= q_nxt;
    end
  end

endmodule

// ===== hdl/cau_pack.sv =====
// ----------------------------------------------------------------------------
// Complex arithmetic unit, result select
// Signs and saturates the quotient and picks the final result and status.
// ----------------------------------------------------------------------------
module cau_pack import cau_pkg::*; #(
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  ctl_t                          ctl_i,
  input  logic signed [DATA_WIDTH-1:0]  res_re_i,
  input  logic signed [DATA_WIDTH-1:0]  res_im_i,
  input  logic [1:0]                    neg_i,
  input  logic [1:0][DATA_WIDTH+1:0]    q_i,
  output logic signed [DATA_WIDTH-1:0]  re_o,
  output logic signed [DATA_WIDTH-1:0]  im_o,
  output status_t                       status_o
);

  localparam int QW = DATA_WIDTH + 2;

  logic [1:0][QW-1:0]         lim, m;
  logic [1:0]                 sat;
  logic [1:0][DATA_WIDTH-1:0] val;
  logic                       any_sat;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      lim[p] = neg_i[p] ? (QW'(1) << (DATA_WIDTH-1))
                        : ((QW'(1) << (DATA_WIDTH-1)) - QW'(1));
      sat[p] = q_i[p] > lim[p];
      m[p]   = sat[p] ? lim[p] : q_i[p];
      m[p]   = neg_i[p] ? (~m[p] + QW'(1)) : m[p];
      val[p] = m[p][DATA_WIDTH-1:0];
    end
    re_o    = res_re_i;
    im_o    = res_im_i;
    any_sat = ctl_i.sat;
    if (ctl_i.is_div) begin
      re_o    = ctl_i.div0 ? '0 : $signed(val[0]);
      im_o    = ctl_i.div0 ? '0 : $signed(val[1]);
      any_sat = |sat;
    end
    priority if (ctl_i.div0) begin
      status_o = ST_DIV0;
    end else if (any_sat) begin
      status_o = ST_SAT;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

// ===== bench/tb_complex_arithmetic_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives operand words with random gaps, predicts each result in software at
// full precision, and checks every result word in order with random stalls.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit import cau_pkg::*;;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int LATENCY = DW + 6;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [2:0]    opcode;
    logic [DW-1:0] a_re, a_im, b_re, b_im;
  } operands_t;

  typedef struct {
    logic [DW-1:0] re, im;
    logic [1:0]    status;
  } cplx_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic signed [DW-1:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DW-1:0] out_res_re, out_res_im;
  logic [1:0] out_status;

  operands_t    pending_ops[$];
  cplx_result_t expected_results[$];
  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;   // while set, neither side idles
  bit  stimulus_done = 1'b0;

  always #5 clk = ~clk;

  complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (.*);

  // Clamp a full-precision value into the signed word range, noting saturation.
  function automatic logic [DW-1:0] clamp_word(input logic signed [127:0] v, inout bit sat);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (DW - 1)) - 1;
    lo = -(128'sd1 <<< (DW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Division and the product shift both truncate toward zero.
  function automatic logic signed [127:0] div_toward_zero(input logic signed [127:0] n,
                                                          input logic signed [127:0] d);
    logic [127:0] mag;
    mag = (n < 0 ? -n : n) / d;
    return n < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic cplx_result_t compute_complex(input operands_t op);
    logic signed [127:0] ar, ai, br, bi, den, one;
    cplx_result_t r;
    bit sat;
    ar = $signed(op.a_re); ai = $signed(op.a_im);
    br = $signed(op.b_re); bi = $signed(op.b_im);
    one = 128'sd1 <<< FB;
    sat = 1'b0;
    r.re = '0; r.im = '0; r.status = ST_OK;
    case (op.opcode)
      OP_ADD: begin
        r.re = clamp_word(ar + br, sat);
        r.im = clamp_word(ai + bi, sat);
      end
      OP_SUB: begin
        r.re = clamp_word(ar - br, sat);
        r.im = clamp_word(ai - bi, sat);
      end
      OP_MUL: begin
        r.re = clamp_word(div_toward_zero(ar * br - ai * bi, one), sat);
        r.im = clamp_word(div_toward_zero(ai * br + ar * bi, one), sat);
      end
      OP_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) r.status = ST_DIV0;
        else begin
          r.re = clamp_word(div_toward_zero((ar * br + ai * bi) * one, den), sat);
          r.im = clamp_word(div_toward_zero((ai * br - ar * bi) * one, den), sat);
        end
      end
      OP_NEG: begin
        r.re = clamp_word(-ar, sat);
        r.im = clamp_word(-ai, sat);
      end
      default: ;
    endcase
    if (sat && r.status == ST_OK) r.status = ST_SAT;
    return r;
  endfunction

  // Random operand value, biased toward the extremes, zero and small magnitudes.
  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 1024)) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_word(input logic [2:0] opc, input logic [DW-1:0] ar, ai, br, bi);
    operands_t op;
    op.opcode = opc; op.a_re = ar; op.a_im = ai; op.b_re = br; op.b_im = bi;
    pending_ops.push_back(op);
  endtask

  // Driver: present the head of the queue, advance on acceptance. An accepted
  // word leaves the queue first, so the head is always the word to present.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(compute_complex(pending_ops.pop_front()));
      end
      if (pending_ops.size() > 0 && (calm || $urandom_range(0, 99) >= 14)) begin
        // Either keep the stalled word, or load the next one.
        if (!(in_valid && in_stall)) begin
          automatic operands_t nxt = pending_ops[0];
          in_opcode <= nxt.opcode;
          in_a_re <= nxt.a_re; in_a_im <= nxt.a_im;
          in_b_re <= nxt.b_re; in_b_im <= nxt.b_im;
        end
        in_valid <= 1'b1;
      end else if (!(in_valid && in_stall)) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result word against the oldest prediction.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 14);
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result re=%h im=%h status=%0d", $time,
                   out_res_re, out_res_im, out_status);
          errors++;
        end else begin
          automatic cplx_result_t e = expected_results.pop_front();
          if (out_res_re !== e.re) begin
            $display("%0t: res_re expected %h actual %h", $time, e.re, out_res_re);
            errors++;
          end
          if (out_res_im !== e.im) begin
            $display("%0t: res_im expected %h actual %h", $time, e.im, out_res_im);
            errors++;
          end
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog against a hung pipeline.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // Directed words: every opcode, extremes, zero divisor, negated minimum,
    // and the unused opcodes.
    for (int o = 0; o < 8; o++) begin
      queue_word(3'(o), 16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    end
    queue_word(OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
    queue_word(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
    queue_word(OP_NEG, 16'h8000, 16'h0001, 16'h0000, 16'h0000);
    queue_word(OP_NEG, 16'hffff, 16'h8000, 16'h1234, 16'h0000);
    queue_word(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    queue_word(OP_MUL, 16'hff00, 16'h0080, 16'h0180, 16'hff80);
    queue_word(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    queue_word(OP_DIV, 16'hff01, 16'h0000, 16'h0003, 16'hfffd);
    queue_word(OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    queue_word(OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    queue_word(OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    queue_word(OP_ADD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    for (int i = 0; i < 800; i++) begin
      queue_word(3'($urandom_range(0, 99) < 95 ? $urandom_range(0, 4) : $urandom_range(5, 7)),
                 pick_value(), pick_value(), pick_value(), pick_value());
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Randomly idling for a while, then a calm stretch, then random again.
    wait (pending_ops.size() < 550);
    calm = 1'b1;
    wait (pending_ops.size() < 350);
    calm = 1'b0;
    wait (pending_ops.size() == 0);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cau_pkg.sv
hdl/cau_mult.sv
hdl/cau_combine.sv
hdl/cau_div_stage.sv
hdl/cau_pack.sv
hdl/complex_arithmetic_unit.sv
bench/tb_complex_arithmetic_unit.sv
